@@ rtl/svpwm_pkg.sv @@
// ============================================================================
// Servo PWM sweep generator package
// Shared widths, register indexes, command codes and sweep bounds.
// ============================================================================
package svpwm_pkg;

  // Field widths
  localparam int unsigned CMD_W     = 8;
  localparam int unsigned PERIOD_W  = 16;
  localparam int unsigned PULSE_W   = 16;
  localparam int unsigned STEP_W    = 10;
  localparam int unsigned HOLD_W    = 24;
  localparam int unsigned INDEX_W   = 7;
  localparam int unsigned KIND_W    = 2;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_W     = 24;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_US   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_PULSE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_NARROW = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_WIDE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_US     = 3'd4;

  // Register reset values
  localparam logic [PERIOD_W-1:0] PERIOD_RST    = 16'd20000;
  localparam logic [PULSE_W-1:0]  MIN_PULSE_RST = 16'd544;
  localparam logic [STEP_W-1:0]   STEP_N_RST    = 10'd21;
  localparam logic [STEP_W-1:0]   STEP_W_RST    = 10'd63;
  localparam logic [HOLD_W-1:0]   HOLD_RST      = 24'd3000000;

  // Input opcodes
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_CMD  = 1'b1;

  // Sweep commands (also the stored sweep kind)
  localparam logic [KIND_W-1:0] KIND_NONE   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_NARROW = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DOWN   = 2'd2;
  localparam logic [KIND_W-1:0] KIND_WIDE   = 2'd3;

  // Sweep index bounds
  localparam logic [INDEX_W-1:0] IDX_LOW_A  = 7'd0;
  localparam logic [INDEX_W-1:0] IDX_HIGH_A = 7'd30;
  localparam logic [INDEX_W-1:0] IDX_LOW_B  = 7'd45;
  localparam logic [INDEX_W-1:0] IDX_HIGH_B = 7'd90;

  localparam logic [HOLD_W-1:0] ELAPSED_MAX = '1;

  // First index of a pass; the last index is the first of the opposite pass
  function automatic logic [INDEX_W-1:0] pass_first(logic [KIND_W-1:0] kind, logic fwd);
    if (kind == KIND_DOWN) begin
      return fwd ? IDX_HIGH_B : IDX_LOW_B;
    end
    return fwd ? IDX_LOW_A : IDX_HIGH_A;
  endfunction

endpackage

@@ rtl/servo_pwm_sweep_generator.sv @@
// ============================================================================
// Servo PWM sweep generator
// Counts microsecond ticks, runs forward / hold / return sweeps on command
// and reports the servo pin level, busy and reject flags for every word.
// ============================================================================
//
//  channel | ports                                   | direction
//  --------+-----------------------------------------+----------
//  in      | in_valid, in_stall, in_opcode, in_command | input word
//  out     | out_valid, out_stall, out_pin_level,    | result word
//          | out_busy_res, out_rejected              |
//  cfg     | cfg_we, cfg_index, cfg_wdata            | register write
//
// One word per cycle while no output stall holds it; each word passes the input
// register, then the sweep update and pulse compare into the result register.
// The pulse width is one 10x7 multiply, an add and a compare per word.
// rst_n is synchronous; control and sweep state clear, registers take defaults.
// An output stall holds the result register and a full input register.
module servo_pwm_sweep_generator (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_opcode,
  input  logic [svpwm_pkg::CMD_W-1:0]     in_command,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_pin_level,
  output logic                            out_busy_res,
  output logic                            out_rejected,
  input  logic                            cfg_we,
  input  logic [svpwm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [svpwm_pkg::CFG_W-1:0]     cfg_wdata
);
  import svpwm_pkg::*;

  typedef enum logic [1:0] {PH_IDLE, PH_FWD, PH_HOLD, PH_RET} phase_t;

  // Configuration registers
  logic [PERIOD_W-1:0] period_us_r;
  logic [PULSE_W-1:0]  min_pulse_r;
  logic [STEP_W-1:0]   step_narrow_r;
  logic [STEP_W-1:0]   step_wide_r;
  logic [HOLD_W-1:0]   hold_us_r;

  // Input stage
  logic             s1_valid_r;
  logic             s1_opcode_r;
  logic [CMD_W-1:0] s1_command_r;
  logic             s1_load;
  logic             advance;

  // Sweep state
  phase_t              phase_r, phase_nxt;
  logic [KIND_W-1:0]   kind_r, kind_nxt;
  logic [INDEX_W-1:0]  index_r, index_nxt;
  logic [PERIOD_W-1:0] pcount_r, pcount_nxt;
  logic [HOLD_W-1:0]   elapsed_r, elapsed_nxt;

  // Result stage
  logic out_valid_r, pin_r, busy_r, rej_r;
  logic pin_nxt, rej_nxt;

  // Tick helpers
  logic [HOLD_W-1:0]   elapsed_inc;
  logic [PERIOD_W-1:0] pcount_inc;
  logic                fwd;
  logic                up;
  logic                period_end;
  logic [STEP_W-1:0]   step_sel;
  logic [STEP_W+INDEX_W-1:0]   step_prod;
  logic [STEP_W+INDEX_W:0]     high_sum;
  logic [PERIOD_W-1:0]         period_eff;

  // Handshake
  assign advance   = !out_valid_r || !out_stall;
  assign in_stall  = s1_valid_r && !advance;
  assign s1_load   = !in_stall;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_us_r   <= PERIOD_RST;
      min_pulse_r   <= MIN_PULSE_RST;
      step_narrow_r <= STEP_N_RST;
      step_wide_r   <= STEP_W_RST;
      hold_us_r     <= HOLD_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PERIOD_US:   period_us_r   <= cfg_wdata[PERIOD_W-1:0];
        CFG_MIN_PULSE:   min_pulse_r   <= cfg_wdata[PULSE_W-1:0];
        CFG_STEP_NARROW: step_narrow_r <= cfg_wdata[STEP_W-1:0];
        CFG_STEP_WIDE:   step_wide_r   <= cfg_wdata[STEP_W-1:0];
        CFG_HOLD_US:     hold_us_r     <= cfg_wdata[HOLD_W-1:0];
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_load) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load && in_valid) begin
      s1_opcode_r  <= in_opcode;
      s1_command_r <= in_command;
    end
  end

  // Sweep update for one word
  assign period_eff  = (period_us_r == '0) ? PERIOD_W'(1) : period_us_r;
  assign elapsed_inc = (elapsed_r == ELAPSED_MAX) ? elapsed_r : elapsed_r + HOLD_W'(1);
  assign pcount_inc  = pcount_r + PERIOD_W'(1);
  assign fwd         = (phase_r == PH_FWD);
  assign up          = (kind_r == KIND_DOWN) ? !fwd : fwd;
  assign period_end  = (pcount_inc == '0) || (pcount_inc >= period_eff);

  always_comb begin
    phase_nxt   = phase_r;
    kind_nxt    = kind_r;
    index_nxt   = index_r;
    pcount_nxt  = pcount_r;
    elapsed_nxt = elapsed_r;
    rej_nxt     = 1'b0;
    if (s1_opcode_r == OP_CMD) begin
      if (phase_r != PH_IDLE) begin
        rej_nxt = 1'b1;
      end else if (s1_command_r >= CMD_W'(KIND_NARROW) &&
                   s1_command_r <= CMD_W'(KIND_WIDE)) begin
        kind_nxt    = s1_command_r[KIND_W-1:0];
        elapsed_nxt = '0;
        phase_nxt   = PH_FWD;
        index_nxt   = pass_first(s1_command_r[KIND_W-1:0], 1'b1);
        pcount_nxt  = '0;
      end
    end else begin
      unique case (phase_r)
        PH_IDLE: ;
        PH_HOLD: begin
          elapsed_nxt = elapsed_inc;
          if (elapsed_inc >= hold_us_r) begin
            phase_nxt  = PH_RET;
            index_nxt  = pass_first(kind_r, 1'b0);
            pcount_nxt = '0;
          end
        end
        PH_FWD, PH_RET: begin
          elapsed_nxt = elapsed_inc;
          if (!period_end) begin
            pcount_nxt = pcount_inc;
          end else begin
            pcount_nxt = '0;
            if (index_r == pass_first(kind_r, !fwd)) begin
              // end of pass
              if (!fwd) begin
                phase_nxt = PH_IDLE;
              end else if (elapsed_inc >= hold_us_r) begin
                phase_nxt = PH_RET;
                index_nxt = pass_first(kind_r, 1'b0);
              end else begin
                phase_nxt = PH_HOLD;
              end
            end else if (up) begin
              index_nxt = index_r + INDEX_W'(1);
            end else begin
              index_nxt = index_r - INDEX_W'(1);
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Pulse width from the updated index, clamped by the period compare
  assign step_sel  = (kind_nxt == KIND_WIDE) ? step_wide_r : step_narrow_r;
  assign step_prod = step_sel * index_nxt;
  assign high_sum  = (STEP_W+INDEX_W+1)'(min_pulse_r) + (STEP_W+INDEX_W+1)'(step_prod);
  assign pin_nxt   = (phase_nxt == PH_FWD || phase_nxt == PH_RET) &&
                     ((STEP_W+INDEX_W+1)'(pcount_nxt) < high_sum) &&
                     (pcount_nxt < period_eff);

  // State and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      kind_r      <= KIND_NONE;
      index_r     <= '0;
      pcount_r    <= '0;
      elapsed_r   <= '0;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
      if (s1_valid_r) begin
        phase_r   <= phase_nxt;
        kind_r    <= kind_nxt;
        index_r   <= index_nxt;
        pcount_r  <= pcount_nxt;
        elapsed_r <= elapsed_nxt;
        pin_r     <= pin_nxt;
        busy_r    <= (phase_nxt != PH_IDLE);
        rej_r     <= rej_nxt;
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_pin_level = pin_r;
  assign out_busy_res  = busy_r;
  assign out_rejected  = rej_r;

  // Checks
  a_rej_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_rejected |-> out_busy_res)
    else $error("reject reported while not busy");

  a_pin_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_pin_level |-> out_busy_res)
    else $error("pin high while idle");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output backpressure");

  a_idle_count: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_IDLE |-> pcount_r == '0)
    else $error("period count not cleared in idle");

endmodule
